// File: hdl/avcc_record_parser_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker of the decoder configuration parser.
// ----------------------------------------------------------------------------
`ifndef AVCC_RECORD_PARSER_MACROS_SVH
`define AVCC_RECORD_PARSER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AVCC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AVCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/avcc_pkg.sv
// ----------------------------------------------------------------------------
// avcc_pkg
// Types and codes shared by the decoder configuration record parser.
// ----------------------------------------------------------------------------
package avcc_pkg;

    // Position within the record.
    typedef enum logic [3:0] {
        PH_VERSION   = 4'd0,
        PH_PROFILE   = 4'd1,
        PH_COMPAT    = 4'd2,
        PH_LEVEL     = 4'd3,
        PH_LENSIZE   = 4'd4,
        PH_SPSCOUNT  = 4'd5,
        PH_SPSLEN_HI = 4'd6,
        PH_SPSLEN_LO = 4'd7,
        PH_SPSDATA   = 4'd8,
        PH_PPSCOUNT  = 4'd9,
        PH_PPSLEN_HI = 4'd10,
        PH_PPSLEN_LO = 4'd11,
        PH_PPSDATA   = 4'd12,
        PH_DONE      = 4'd13
    } t_phase;

    // Classification of each echoed byte.
    typedef enum logic [3:0] {
        CLS_VERSION  = 4'd0,
        CLS_PROFILE  = 4'd1,
        CLS_COMPAT   = 4'd2,
        CLS_LEVEL    = 4'd3,
        CLS_LENSIZE  = 4'd4,
        CLS_SPSCOUNT = 4'd5,
        CLS_SPSLEN   = 4'd6,
        CLS_SPSDATA  = 4'd7,
        CLS_PPSCOUNT = 4'd8,
        CLS_PPSLEN   = 4'd9,
        CLS_PPSDATA  = 4'd10,
        CLS_TRAILING = 4'd11
    } t_class;

    // One result beat as produced by the parser step.
    typedef struct packed {
        t_class      cls;
        logic [7:0]  value;
        logic [7:0]  idx;
        logic        last;
        logic [1:0]  lsm1;
        logic        done;
    } t_result;

    // Width of the packed output tdata (19 field bits padded to bytes).
    localparam int unsigned OUT_TDATA_W = 24;

endpackage

// File: hdl/avcc_parse.sv
// ----------------------------------------------------------------------------
// avcc_parse
// Parser state machine: classifies one record byte per step and updates the
// phase, entry counters and length registers.
// ----------------------------------------------------------------------------
module avcc_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_data,
    input  logic              i_start,
    output avcc_pkg::t_result o_result
);

    avcc_pkg::t_phase r_phase, n_phase, e_phase;
    logic [7:0]       r_sets, n_sets, e_sets;
    logic [15:0]      r_bytes, n_bytes, e_bytes;
    logic [7:0]       r_hi, n_hi, e_hi;
    logic [7:0]       r_cnt, n_cnt, e_cnt;
    logic [1:0]       r_lsz, n_lsz, e_lsz;
    logic             r_done, n_done, e_done;

    logic             w_pps;
    logic             w_finish;
    logic [7:0]       w_sets_dec;
    logic [15:0]      w_len;

    // A record start makes the byte look as if it arrived straight after reset.
    always_comb begin
        if (i_start) begin
            e_phase = avcc_pkg::PH_VERSION;
            e_sets  = '0;
            e_bytes = '0;
            e_hi    = '0;
            e_cnt   = '0;
            e_lsz   = '0;
            e_done  = 1'b0;
        end else begin
            e_phase = r_phase;
            e_sets  = r_sets;
            e_bytes = r_bytes;
            e_hi    = r_hi;
            e_cnt   = r_cnt;
            e_lsz   = r_lsz;
            e_done  = r_done;
        end
    end

    assign w_pps      = (e_phase == avcc_pkg::PH_PPSLEN_LO) ||
                        (e_phase == avcc_pkg::PH_PPSDATA);
    assign w_sets_dec = e_sets - 8'd1;
    assign w_len      = {e_hi, i_data};

    // Next-state logic.
    always_comb begin
        n_phase  = e_phase;
        n_sets   = e_sets;
        n_bytes  = e_bytes;
        n_hi     = e_hi;
        n_cnt    = e_cnt;
        n_lsz    = e_lsz;
        n_done   = e_done;
        w_finish = 1'b0;
        case (e_phase)
            avcc_pkg::PH_VERSION: begin
                n_phase = avcc_pkg::PH_PROFILE;
            end
            avcc_pkg::PH_PROFILE: begin
                n_phase = avcc_pkg::PH_COMPAT;
            end
            avcc_pkg::PH_COMPAT: begin
                n_phase = avcc_pkg::PH_LEVEL;
            end
            avcc_pkg::PH_LEVEL: begin
                n_phase = avcc_pkg::PH_LENSIZE;
            end
            avcc_pkg::PH_LENSIZE: begin
                n_lsz   = i_data[1:0];
                n_phase = avcc_pkg::PH_SPSCOUNT;
            end
            avcc_pkg::PH_SPSCOUNT: begin
                // Top three bits of the count byte are reserved.
                n_sets  = {3'b000, i_data[4:0]};
                n_cnt   = '0;
                n_phase = (i_data[4:0] != 5'd0) ? avcc_pkg::PH_SPSLEN_HI
                                                : avcc_pkg::PH_PPSCOUNT;
            end
            avcc_pkg::PH_PPSCOUNT: begin
                n_sets = i_data;
                n_cnt  = '0;
                if (i_data != 8'd0) begin
                    n_phase = avcc_pkg::PH_PPSLEN_HI;
                end else begin
                    n_phase = avcc_pkg::PH_DONE;
                    n_done  = 1'b1;
                end
            end
            avcc_pkg::PH_SPSLEN_HI: begin
                n_hi    = i_data;
                n_phase = avcc_pkg::PH_SPSLEN_LO;
            end
            avcc_pkg::PH_PPSLEN_HI: begin
                n_hi    = i_data;
                n_phase = avcc_pkg::PH_PPSLEN_LO;
            end
            avcc_pkg::PH_SPSLEN_LO, avcc_pkg::PH_PPSLEN_LO: begin
                if (w_len == 16'd0) begin
                    w_finish = 1'b1;
                end else begin
                    n_bytes = w_len;
                    n_phase = w_pps ? avcc_pkg::PH_PPSDATA : avcc_pkg::PH_SPSDATA;
                end
            end
            avcc_pkg::PH_SPSDATA, avcc_pkg::PH_PPSDATA: begin
                n_bytes  = e_bytes - 16'd1;
                w_finish = (e_bytes == 16'd1);
            end
            default: begin
                n_phase = avcc_pkg::PH_DONE;
            end
        endcase

        // End of one entry: move to the next entry, the PPS count or done.
        if (w_finish) begin
            n_cnt  = e_cnt + 8'd1;
            n_sets = w_sets_dec;
            if (w_sets_dec != 8'd0) begin
                n_phase = w_pps ? avcc_pkg::PH_PPSLEN_HI : avcc_pkg::PH_SPSLEN_HI;
            end else if (w_pps) begin
                n_phase = avcc_pkg::PH_DONE;
                n_done  = 1'b1;
            end else begin
                n_phase = avcc_pkg::PH_PPSCOUNT;
            end
        end
    end

    // Output logic: class, entry index and last-payload mark.
    always_comb begin
        o_result.cls   = avcc_pkg::CLS_TRAILING;
        o_result.value = i_data;
        o_result.idx   = '0;
        o_result.last  = 1'b0;
        o_result.lsm1  = n_lsz;
        o_result.done  = n_done;
        case (e_phase)
            avcc_pkg::PH_VERSION:  o_result.cls = avcc_pkg::CLS_VERSION;
            avcc_pkg::PH_PROFILE:  o_result.cls = avcc_pkg::CLS_PROFILE;
            avcc_pkg::PH_COMPAT:   o_result.cls = avcc_pkg::CLS_COMPAT;
            avcc_pkg::PH_LEVEL:    o_result.cls = avcc_pkg::CLS_LEVEL;
            avcc_pkg::PH_LENSIZE:  o_result.cls = avcc_pkg::CLS_LENSIZE;
            avcc_pkg::PH_SPSCOUNT: o_result.cls = avcc_pkg::CLS_SPSCOUNT;
            avcc_pkg::PH_PPSCOUNT: o_result.cls = avcc_pkg::CLS_PPSCOUNT;
            avcc_pkg::PH_SPSLEN_HI, avcc_pkg::PH_SPSLEN_LO: begin
                o_result.cls = avcc_pkg::CLS_SPSLEN;
                o_result.idx = e_cnt;
            end
            avcc_pkg::PH_PPSLEN_HI, avcc_pkg::PH_PPSLEN_LO: begin
                o_result.cls = avcc_pkg::CLS_PPSLEN;
                o_result.idx = e_cnt;
            end
            avcc_pkg::PH_SPSDATA: begin
                o_result.cls  = avcc_pkg::CLS_SPSDATA;
                o_result.idx  = e_cnt;
                o_result.last = (e_bytes == 16'd1);
            end
            avcc_pkg::PH_PPSDATA: begin
                o_result.cls  = avcc_pkg::CLS_PPSDATA;
                o_result.idx  = e_cnt;
                o_result.last = (e_bytes == 16'd1);
            end
            default: begin
                o_result.cls = avcc_pkg::CLS_TRAILING;
            end
        endcase
    end

    // State registers advance on every accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= avcc_pkg::PH_VERSION;
            r_sets  <= '0;
            r_bytes <= '0;
            r_hi    <= '0;
            r_cnt   <= '0;
            r_lsz   <= '0;
            r_done  <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_sets  <= n_sets;
            r_bytes <= n_bytes;
            r_hi    <= n_hi;
            r_cnt   <= n_cnt;
            r_lsz   <= n_lsz;
            r_done  <= n_done;
        end
    end

endmodule

// File: hdl/avcc_record_parser.sv
// ----------------------------------------------------------------------------
// avcc_record_parser
// Byte-wise parser of an H.264 decoder configuration record.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one record byte per beat in s_axis_tdata, with
//   s_axis_tuser high on the first byte of a record to restart the parser.
//   The master stream returns exactly one beat per input byte: the class in
//   m_axis_tuser, the echoed byte, entry index, length size minus one and
//   done flag in m_axis_tdata, and m_axis_tlast on the last payload byte of
//   every SPS or PPS entry.
//   A byte accepted at a clock edge is registered and presented on the master
//   side in the cycle after. Throughput is one byte per cycle while the
//   receiver takes every beat, set by the combinational parser step.
//   When the receiver stalls, the result is held in the output register and
//   the slave side stops accepting until that beat is taken; the output
//   register is refilled in the same cycle it drains.
//   Reset clears the parser to expect a version byte and empties the output
//   register; no byte is accepted while reset is asserted.
// ----------------------------------------------------------------------------
module avcc_record_parser (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [7:0] data_byte
    input  logic                              s_axis_tuser,  // [0] record_start
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] byte_value, [15:8] set_index, [17:16] length_size_minus_one,
    // [18] record_done, [23:19] zero
    output logic [avcc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic [3:0]                        m_axis_tuser,  // [3:0] byte_class
    output logic                              m_axis_tlast   // payload_last
);

    logic              w_accept;
    avcc_pkg::t_result w_result;
    avcc_pkg::t_result r_out;
    logic              r_out_valid, n_out_valid;

    // The slave side is open whenever the output register is empty or draining.
    assign s_axis_tready = i_rst_n && (!r_out_valid || m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    avcc_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_accept),
        .i_data   (s_axis_tdata),
        .i_start  (s_axis_tuser),
        .o_result (w_result)
    );

    // Output register occupancy.
    always_comb begin
        if (w_accept) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload is captured on each accepted byte.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= w_result;
        end
    end

    // Master-side packing.
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.cls;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {5'b00000, r_out.done, r_out.lsm1, r_out.idx, r_out.value};

endmodule

// File: hdl/avcc_checker.sv
// ----------------------------------------------------------------------------
// avcc_checker
// Port-level checks on the decoder configuration record parser.
// ----------------------------------------------------------------------------
`include "avcc_record_parser_macros.svh"

module avcc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [7:0]                        s_axis_tdata,
    input logic                              s_axis_tuser,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [avcc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic [3:0]                        m_axis_tuser,
    input logic                              m_axis_tlast
);

    logic                               w_stall;
    logic [avcc_pkg::OUT_TDATA_W+5:0]   w_beat;
    logic                               w_restart;
    logic                               w_version_echo;
    logic                               w_last;
    logic                               w_payload;
    logic                               w_len_byte;
    logic                               w_no_index;
    logic                               w_idx_zero;
    logic [7:0]                         r_in_byte;

    // Everything the master side presents, for the stall check.
    assign w_stall = m_axis_tvalid && !m_axis_tready;
    assign w_beat  = {m_axis_tvalid, m_axis_tlast, m_axis_tuser, m_axis_tdata};

    // The slave byte of the previous cycle, to compare with its echo.
    always_ff @(posedge i_clk) begin
        r_in_byte <= s_axis_tdata;
    end

    assign w_restart      = s_axis_tvalid && s_axis_tready && s_axis_tuser;
    assign w_version_echo = m_axis_tvalid && (m_axis_tuser == avcc_pkg::CLS_VERSION) &&
                            (m_axis_tdata[7:0] == r_in_byte);

    // Classes that carry an entry index.
    assign w_payload  = (m_axis_tuser == avcc_pkg::CLS_SPSDATA) ||
                        (m_axis_tuser == avcc_pkg::CLS_PPSDATA);
    assign w_len_byte = (m_axis_tuser == avcc_pkg::CLS_SPSLEN) ||
                        (m_axis_tuser == avcc_pkg::CLS_PPSLEN);
    assign w_last     = m_axis_tvalid && m_axis_tlast;
    assign w_no_index = m_axis_tvalid && !w_payload && !w_len_byte;
    assign w_idx_zero = (m_axis_tdata[15:8] == 8'd0);

    // A stalled result beat stays presented and unchanged.
    `AVCC_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, w_stall, $stable(w_beat), "stall changed beat")

    // A restart byte comes out next as the version byte, value echoed.
    `AVCC_ASSERT_NEXT(a_restart, i_clk, i_rst_n, w_restart, w_version_echo, "restart not version")

    // The last-payload mark appears only on payload bytes.
    `AVCC_ASSERT_SAME(a_last_on_payload, i_clk, i_rst_n, w_last, w_payload, "tlast outside payload")

    // Entry index is zero outside length and payload bytes.
    `AVCC_ASSERT_SAME(a_index_zero, i_clk, i_rst_n, w_no_index, w_idx_zero, "index on header byte")

endmodule

bind avcc_record_parser avcc_checker u_avcc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
